>>> rtl/tem_pkg.sv
// ----------------------------------------------------------------------------
// tem_pkg: shared types and constants of the trajectory extrema block
// Holds the request and result payloads, the extrema record, the divider
// handshake structs, the sequencer states and the register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tem_pkg;

  // Fraction bits of the three ratio outputs.
  localparam int RATIO_FRAC_BITS = 16;

  // Field widths.
  localparam int TIME_W  = 48;
  localparam int RAD_W   = 32;
  localparam int TEMP_W  = 32;
  localparam int PRES_W  = 48;
  localparam int VEL_W   = 32;
  localparam int RATIO_W = 32;
  localparam int FLAGS_W = 6;
  localparam int SPEED_W = 31;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Serial divider: one quotient bit per cycle over the scaled dividend.
  localparam int DIV_W     = 48;
  localparam int NUM_W     = DIV_W + RATIO_FRAC_BITS;
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  // Flag bit positions.
  localparam int FLAG_NEAR  = 0;
  localparam int FLAG_COMP  = 1;
  localparam int FLAG_HEAT  = 2;
  localparam int FLAG_PRES  = 3;
  localparam int FLAG_SPEED = 4;
  localparam int FLAG_ALL   = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INITIAL_RADIUS      = 3'd0,
    CFG_INITIAL_TEMPERATURE = 3'd1,
    CFG_STATIC_PRESSURE     = 3'd2,
    CFG_CORE_RADIUS         = 3'd3,
    CFG_MIN_COMPRESSION     = 3'd4,
    CFG_MIN_TEMPERATURE     = 3'd5,
    CFG_MIN_PRESSURE        = 3'd6,
    CFG_MIN_INWARD_SPEED    = 3'd7
  } tem_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CR,
    ST_TG,
    ST_PG,
    ST_EMIT
  } tem_state_e;

  typedef struct packed {
    logic [TIME_W-1:0]       sample_time;
    logic [RAD_W-1:0]        radius;
    logic [TEMP_W-1:0]       gas_temp;
    logic [PRES_W-1:0]       gas_pressure;
    logic signed [VEL_W-1:0] wall_velocity;
    logic                    last;
  } tem_sample_t;

  typedef struct packed {
    logic [RAD_W-1:0]   least_radius;
    logic [TIME_W-1:0]  least_radius_time;
    logic [TEMP_W-1:0]  peak_temp;
    logic [TIME_W-1:0]  peak_temp_time;
    logic [PRES_W-1:0]  peak_pressure;
    logic [TIME_W-1:0]  peak_pressure_time;
    logic [VEL_W-1:0]   peak_inward;
    logic [TIME_W-1:0]  peak_inward_time;
  } tem_extrema_t;

  typedef struct packed {
    logic [RAD_W-1:0]   least_radius;
    logic [TIME_W-1:0]  least_radius_time;
    logic [TEMP_W-1:0]  peak_temp;
    logic [TIME_W-1:0]  peak_temp_time;
    logic [PRES_W-1:0]  peak_pressure;
    logic [TIME_W-1:0]  peak_pressure_time;
    logic [VEL_W-1:0]   peak_inward;
    logic [TIME_W-1:0]  peak_inward_time;
    logic [RATIO_W-1:0] compression_ratio;
    logic [RATIO_W-1:0] temp_gain;
    logic [RATIO_W-1:0] pressure_gain;
    logic [FLAGS_W-1:0] flags;
  } tem_result_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } tem_div_req_t;

  typedef struct packed {
    logic               done;
    logic [RATIO_W-1:0] quot;
  } tem_div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/tem_ifs.sv
// ----------------------------------------------------------------------------
// tem_ifs: sample and result channels
// Valid/ready channels; a request moves at a clock edge with both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tem_sample_if;
  logic                 valid;
  logic                 ready;
  tem_pkg::tem_sample_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tem_result_if;
  logic                 valid;
  logic                 ready;
  tem_pkg::tem_result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/tem_tracker.sv
// ----------------------------------------------------------------------------
// tem_tracker: running extrema of one trajectory
// Compares each accepted sample against the stored extrema and latches the
// new value and its time on a strict improvement. The first sample seeds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tem_tracker (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  upd_i,
  input  wire tem_pkg::tem_sample_t  sample_i,
  output tem_pkg::tem_extrema_t      ext_o
);

  logic                           first_q;
  tem_pkg::tem_extrema_t          ext_q;
  tem_pkg::tem_extrema_t          ext_d;
  logic                           inward;
  logic [tem_pkg::VEL_W-1:0]      speed;

  // Inward speed is the magnitude of a negative velocity.
  always_comb begin
    inward = sample_i.wall_velocity[tem_pkg::VEL_W-1];
    speed  = (~sample_i.wall_velocity) + tem_pkg::VEL_W'(1);
  end

  // Seed or update the extrema.
  always_comb begin
    ext_d = ext_q;
    if (first_q) begin
      ext_d.least_radius       = sample_i.radius;
      ext_d.least_radius_time  = sample_i.sample_time;
      ext_d.peak_temp          = sample_i.gas_temp;
      ext_d.peak_temp_time     = sample_i.sample_time;
      ext_d.peak_pressure      = sample_i.gas_pressure;
      ext_d.peak_pressure_time = sample_i.sample_time;
      if (inward) begin
        ext_d.peak_inward      = speed;
        ext_d.peak_inward_time = sample_i.sample_time;
      end else begin
        ext_d.peak_inward      = '0;
        ext_d.peak_inward_time = '0;
      end
    end else begin
      if (sample_i.radius < ext_q.least_radius) begin
        ext_d.least_radius      = sample_i.radius;
        ext_d.least_radius_time = sample_i.sample_time;
      end
      if (sample_i.gas_temp > ext_q.peak_temp) begin
        ext_d.peak_temp      = sample_i.gas_temp;
        ext_d.peak_temp_time = sample_i.sample_time;
      end
      if (sample_i.gas_pressure > ext_q.peak_pressure) begin
        ext_d.peak_pressure      = sample_i.gas_pressure;
        ext_d.peak_pressure_time = sample_i.sample_time;
      end
      if (inward && (speed > ext_q.peak_inward)) begin
        ext_d.peak_inward      = speed;
        ext_d.peak_inward_time = sample_i.sample_time;
      end
    end
  end

  // The sample after a last one starts a new trajectory.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (upd_i) begin
      first_q <= sample_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i) begin
      ext_q <= ext_d;
    end
  end

  assign ext_o = ext_q;

endmodule

`default_nettype wire

>>> rtl/tem_divider.sv
// ----------------------------------------------------------------------------
// tem_divider: shared restoring divider for the fixed-point ratios
// Produces floor(num * 2^RATIO_FRAC_BITS / den), one quotient bit a cycle,
// saturated to all ones when it does not fit, and zero for a zero divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tem_divider (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire tem_pkg::tem_div_req_t req_i,
  output tem_pkg::tem_div_rsp_t      rsp_o
);

  logic                              busy_q, busy_d;
  logic [tem_pkg::CNT_W-1:0]         cnt_q, cnt_d;
  logic [tem_pkg::DIV_W-1:0]         rem_q, rem_d;
  logic [tem_pkg::DIV_W-1:0]         den_q, den_d;
  logic [tem_pkg::NUM_W-1:0]         dvd_q, dvd_d;
  logic [tem_pkg::RATIO_W-1:0]       quo_q, quo_d;
  logic                              ovf_q, ovf_d;
  logic [tem_pkg::DIV_W:0]           rem_ext;
  logic [tem_pkg::DIV_W:0]           diff;
  logic                              ge;
  logic                              done;

  // One restoring step: shift in the next dividend bit, try to subtract.
  always_comb begin
    rem_ext = {rem_q, dvd_q[tem_pkg::NUM_W-1]};
    diff    = rem_ext - {1'b0, den_q};
    ge      = (rem_ext >= {1'b0, den_q});
    done    = busy_q && (cnt_q == '0);
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      rem_d  = '0;
      den_d  = req_i.den;
      dvd_d  = {req_i.num, {tem_pkg::RATIO_FRAC_BITS{1'b0}}};
      quo_d  = '0;
      ovf_d  = 1'b0;
      // A zero divisor finishes at once with a zero result.
      cnt_d  = (req_i.den == '0) ? '0 : tem_pkg::CNT_W'(tem_pkg::DIV_STEPS);
    end else if (done) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      cnt_d = cnt_q - tem_pkg::CNT_W'(1);
      rem_d = ge ? diff[tem_pkg::DIV_W-1:0] : rem_ext[tem_pkg::DIV_W-1:0];
      dvd_d = dvd_q << 1;
      // Any quotient bit pushed past the top forces saturation.
      ovf_d = ovf_q | quo_q[tem_pkg::RATIO_W-1];
      quo_d = {quo_q[tem_pkg::RATIO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  assign rsp_o.done = done;
  assign rsp_o.quot = ovf_q ? '1 : quo_q;

endmodule

`default_nettype wire

>>> rtl/trajectory_extrema_metrics.sv
// ----------------------------------------------------------------------------
// trajectory_extrema_metrics: extrema and ratios of a bubble trajectory
// Tracks minimum radius, peak temperature, peak pressure and peak inward
// speed with their times, and reports them with three ratios and flags.
// ----------------------------------------------------------------------------
// Samples that are not marked last may stream one per cycle. A sample
// marked last closes the trajectory: the block then drops ready while one
// shared serial divider works out the compression ratio, the temperature
// gain and the pressure gain in turn. The result sits in an output
// register until taken, and new samples are accepted while it waits.
`timescale 1ns / 1ps
`default_nettype none

module trajectory_extrema_metrics (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  tem_sample_if.sink                              sample_i,
  tem_result_if.source                            result_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [tem_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [tem_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // Configuration registers.
  logic [tem_pkg::RAD_W-1:0]    initial_radius_q;
  logic [tem_pkg::TEMP_W-1:0]   initial_temperature_q;
  logic [tem_pkg::PRES_W-1:0]   static_pressure_q;
  logic [tem_pkg::RAD_W-1:0]    core_radius_q;
  logic [tem_pkg::RATIO_W-1:0]  min_compression_q;
  logic [tem_pkg::TEMP_W-1:0]   min_temperature_q;
  logic [tem_pkg::PRES_W-1:0]   min_pressure_q;
  logic [tem_pkg::SPEED_W-1:0]  min_inward_speed_q;

  tem_pkg::tem_state_e          state_q, state_d;
  logic                         start_q, start_d;
  logic [tem_pkg::RATIO_W-1:0]  cr_q, cr_d;
  logic [tem_pkg::RATIO_W-1:0]  tg_q, tg_d;
  logic [tem_pkg::RATIO_W-1:0]  pg_q, pg_d;
  logic                         res_valid_q, res_valid_d;
  tem_pkg::tem_result_t         res_q, res_d;

  logic                         in_ready;
  logic                         in_accept;
  tem_pkg::tem_extrema_t        ext;
  tem_pkg::tem_div_req_t        div_req;
  tem_pkg::tem_div_rsp_t        div_rsp;
  logic [tem_pkg::FLAGS_W-1:0]  flags;
  logic [tem_pkg::RAD_W+2:0]    near_lhs;
  logic [tem_pkg::RAD_W+2:0]    near_rhs;

  assign in_ready       = (state_q == tem_pkg::ST_IDLE);
  assign in_accept      = sample_i.valid && in_ready;
  assign sample_i.ready = in_ready;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initial_radius_q      <= '0;
      initial_temperature_q <= '0;
      static_pressure_q     <= '0;
      core_radius_q         <= '0;
      min_compression_q     <= '0;
      min_temperature_q     <= '0;
      min_pressure_q        <= '0;
      min_inward_speed_q    <= '0;
    end else if (cfg_we_i) begin
      case (tem_pkg::tem_cfg_idx_e'(cfg_idx_i))
        tem_pkg::CFG_INITIAL_RADIUS:      initial_radius_q <= cfg_data_i[tem_pkg::RAD_W-1:0];
        tem_pkg::CFG_INITIAL_TEMPERATURE: begin
          initial_temperature_q <= cfg_data_i[tem_pkg::TEMP_W-1:0];
        end
        tem_pkg::CFG_STATIC_PRESSURE:     static_pressure_q <= cfg_data_i[tem_pkg::PRES_W-1:0];
        tem_pkg::CFG_CORE_RADIUS:         core_radius_q <= cfg_data_i[tem_pkg::RAD_W-1:0];
        tem_pkg::CFG_MIN_COMPRESSION:     min_compression_q <= cfg_data_i[tem_pkg::RATIO_W-1:0];
        tem_pkg::CFG_MIN_TEMPERATURE:     min_temperature_q <= cfg_data_i[tem_pkg::TEMP_W-1:0];
        tem_pkg::CFG_MIN_PRESSURE:        min_pressure_q <= cfg_data_i[tem_pkg::PRES_W-1:0];
        tem_pkg::CFG_MIN_INWARD_SPEED:    begin
          min_inward_speed_q <= cfg_data_i[tem_pkg::SPEED_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Extrema tracking.
  tem_tracker u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (in_accept),
    .sample_i (sample_i.data),
    .ext_o    (ext)
  );

  // Shared divider; operands follow the sequencer state.
  always_comb begin
    div_req.start = start_q;
    case (state_q)
      tem_pkg::ST_CR: begin
        div_req.num = tem_pkg::DIV_W'(initial_radius_q);
        div_req.den = tem_pkg::DIV_W'(ext.least_radius);
      end
      tem_pkg::ST_TG: begin
        div_req.num = tem_pkg::DIV_W'(ext.peak_temp);
        div_req.den = tem_pkg::DIV_W'(initial_temperature_q);
      end
      default: begin
        div_req.num = ext.peak_pressure;
        div_req.den = static_pressure_q;
      end
    endcase
  end

  tem_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Flags from the final extrema and ratios; near core is 5*r <= 6*core.
  always_comb begin
    near_lhs = (tem_pkg::RAD_W+3)'(ext.least_radius) * (tem_pkg::RAD_W+3)'(5);
    near_rhs = (tem_pkg::RAD_W+3)'(core_radius_q) * (tem_pkg::RAD_W+3)'(6);
    flags = '0;
    flags[tem_pkg::FLAG_NEAR]  = (ext.least_radius != '0) && (core_radius_q != '0) &&
                                 (near_lhs <= near_rhs);
    flags[tem_pkg::FLAG_COMP]  = (cr_q >= min_compression_q);
    flags[tem_pkg::FLAG_HEAT]  = (ext.peak_temp >= min_temperature_q);
    flags[tem_pkg::FLAG_PRES]  = (ext.peak_pressure >= min_pressure_q);
    flags[tem_pkg::FLAG_SPEED] = (ext.peak_inward >= tem_pkg::VEL_W'(min_inward_speed_q));
    flags[tem_pkg::FLAG_ALL]   = flags[tem_pkg::FLAG_COMP] && flags[tem_pkg::FLAG_HEAT] &&
                                 flags[tem_pkg::FLAG_PRES] && flags[tem_pkg::FLAG_SPEED];
  end

  // Sequencer: next state and result register loading.
  always_comb begin
    state_d     = state_q;
    start_d     = 1'b0;
    cr_d        = cr_q;
    tg_d        = tg_q;
    pg_d        = pg_q;
    res_valid_d = res_valid_q;
    res_d       = res_q;
    if (res_valid_q && result_o.ready) begin
      res_valid_d = 1'b0;
    end
    case (state_q)
      tem_pkg::ST_IDLE: begin
        if (in_accept && sample_i.data.last) begin
          state_d = tem_pkg::ST_CR;
          start_d = 1'b1;
        end
      end
      tem_pkg::ST_CR: begin
        if (div_rsp.done) begin
          cr_d    = div_rsp.quot;
          state_d = tem_pkg::ST_TG;
          start_d = 1'b1;
        end
      end
      tem_pkg::ST_TG: begin
        if (div_rsp.done) begin
          tg_d    = div_rsp.quot;
          state_d = tem_pkg::ST_PG;
          start_d = 1'b1;
        end
      end
      tem_pkg::ST_PG: begin
        if (div_rsp.done) begin
          pg_d    = div_rsp.quot;
          state_d = tem_pkg::ST_EMIT;
        end
      end
      tem_pkg::ST_EMIT: begin
        // Load the output register once it is free.
        if (!res_valid_q || result_o.ready) begin
          res_d.least_radius       = ext.least_radius;
          res_d.least_radius_time  = ext.least_radius_time;
          res_d.peak_temp          = ext.peak_temp;
          res_d.peak_temp_time     = ext.peak_temp_time;
          res_d.peak_pressure      = ext.peak_pressure;
          res_d.peak_pressure_time = ext.peak_pressure_time;
          res_d.peak_inward        = ext.peak_inward;
          res_d.peak_inward_time   = ext.peak_inward_time;
          res_d.compression_ratio  = cr_q;
          res_d.temp_gain          = tg_q;
          res_d.pressure_gain      = pg_q;
          res_d.flags              = flags;
          res_valid_d              = 1'b1;
          state_d                  = tem_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tem_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tem_pkg::ST_IDLE;
      start_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cr_q  <= cr_d;
    tg_q  <= tg_d;
    pg_q  <= pg_d;
    res_q <= res_d;
  end

  assign result_o.valid = res_valid_q;
  assign result_o.data  = res_q;

endmodule

`default_nettype wire

>>> rtl/tem_checker.sv
// ----------------------------------------------------------------------------
// tem_checker: port-level checks of the trajectory extrema block
// Watches the sample and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tem_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 in_last,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire tem_pkg::tem_result_t out_data
);

  // A pending result stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped before it was taken");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // Closing a trajectory occupies the divider, so no sample follows at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("sample taken right after a last sample");

  // The combined flag is the AND of the four threshold flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_data.flags[tem_pkg::FLAG_ALL] ==
                   (out_data.flags[tem_pkg::FLAG_COMP] && out_data.flags[tem_pkg::FLAG_HEAT] &&
                    out_data.flags[tem_pkg::FLAG_PRES] && out_data.flags[tem_pkg::FLAG_SPEED])))
    else $error("combined flag disagrees with threshold flags");

endmodule

bind trajectory_extrema_metrics tem_checker u_tem_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (sample_i.valid),
  .in_ready  (sample_i.ready),
  .in_last   (sample_i.data.last),
  .out_valid (result_o.valid),
  .out_ready (result_o.ready),
  .out_data  (result_o.data)
);

`default_nettype wire
